### src/kpsl_pkg.sv
// ----------------------------------------------------------------------------
// kpsl_pkg
// Shared sizes, types and codes of the rank-k point selector.
// ----------------------------------------------------------------------------
package kpsl_pkg;

    // set and point geometry
    localparam int MAX_POINTS  = 64;
    localparam int MAX_DIMS    = 4;
    localparam int COORD_WIDTH = 32;

    // field widths
    localparam int LABEL_W = 16;
    localparam int RANK_W  = 6;
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int AXC_W   = 3;
    localparam int AXS_W   = 2;
    localparam int EFF_W   = $clog2(MAX_DIMS + 1);
    localparam int AX_W    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = AXC_W;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_AXIS = 2'd1;

    // result status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef logic [MAX_DIMS-1:0][COORD_WIDTH-1:0] coords_t;
    typedef logic [AX_W-1:0] axis_idx_t;

    // controller states
    typedef enum logic
    {
        ST_LOAD,
        ST_DRAIN
    } state_t;

    // control broadcast to every cell of the chain
    typedef struct packed
    {
        logic                      insert;
        logic                      shift;
        logic [EFF_W-1:0]          eff_cnt;
        logic [MAX_DIMS-1:0][AX_W-1:0] axis_order;
    } cell_ctrl_t;

endpackage

### src/kpsl_if.sv
// ----------------------------------------------------------------------------
// kpsl_point_if / kpsl_result_if
// Valid/ready channels for incoming points and outgoing results.
// ----------------------------------------------------------------------------
interface kpsl_point_if;
    import kpsl_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [LABEL_W-1:0]            point_label;
    logic signed [COORD_WIDTH-1:0] coord_0;
    logic signed [COORD_WIDTH-1:0] coord_1;
    logic signed [COORD_WIDTH-1:0] coord_2;
    logic signed [COORD_WIDTH-1:0] coord_3;
    logic [RANK_W-1:0]             target_rank;
    logic                          last_point;

    modport source
    (
        output valid, point_label, coord_0, coord_1, coord_2, coord_3,
               target_rank, last_point,
        input  ready
    );

    modport sink
    (
        input  valid, point_label, coord_0, coord_1, coord_2, coord_3,
               target_rank, last_point,
        output ready
    );
endinterface

interface kpsl_result_if;
    import kpsl_pkg::*;

    logic               valid;
    logic               ready;
    logic [LABEL_W-1:0] selected_label;
    logic               status;

    modport source
    (
        output valid, selected_label, status,
        input  ready
    );

    modport sink
    (
        input  valid, selected_label, status,
        output ready
    );
endinterface

### src/kpsl_cell.sv
// ----------------------------------------------------------------------------
// kpsl_cell
// One slot of the insertion chain: holds a point, compares it against the
// incoming key and keeps it, takes the key or left neighbor, or next_label.
// ----------------------------------------------------------------------------
module kpsl_cell
(
    input  logic                         clk,
    input  kpsl_pkg::cell_ctrl_t         ctrl,
    input  logic                         occupied,
    input  logic [kpsl_pkg::LABEL_W-1:0] key_label,
    input  kpsl_pkg::coords_t            key_coords,
    input  logic                         prev_gt,
    input  logic [kpsl_pkg::LABEL_W-1:0] prev_label,
    input  kpsl_pkg::coords_t            prev_coords,
    input  logic [kpsl_pkg::LABEL_W-1:0] next_label,
    output logic                         gt,
    output logic [kpsl_pkg::LABEL_W-1:0] label,
    output kpsl_pkg::coords_t            coords
);
    import kpsl_pkg::*;

    logic [LABEL_W-1:0] label_reg;
    logic [LABEL_W-1:0] label_next;
    coords_t            coords_reg;
    coords_t            coords_next;
    logic               stored_gt;

    // cyclic lexicographic compare: stored point strictly after the key
    always_comb
    begin
        logic      decided;
        axis_idx_t ax;
        decided   = 1'b0;
        stored_gt = 1'b0;
        ax        = '0;
        for (int off = 0; off < MAX_DIMS; off++)
        begin
            ax = ctrl.axis_order[off];
            if (!decided && (EFF_W'(off) < ctrl.eff_cnt) &&
                (coords_reg[ax] != key_coords[ax]))
            begin
                decided   = 1'b1;
                stored_gt = $signed(coords_reg[ax]) > $signed(key_coords[ax]);
            end
        end
    end

    // at or past the insertion point: set once any cell to the left is;
    // an empty slot sorts after everything; ties keep arrival order
    assign gt = prev_gt || !occupied || stored_gt;

    // slot update: insert, shift right, or drain labels left
    always_comb
    begin
        label_next  = label_reg;
        coords_next = coords_reg;
        if (ctrl.insert && gt)
        begin
            if (prev_gt)
            begin
                label_next  = prev_label;
                coords_next = prev_coords;
            end
            else
            begin
                label_next  = key_label;
                coords_next = key_coords;
            end
        end
        else if (ctrl.shift)
        begin
            label_next = next_label;
        end
    end

    always_ff @(posedge clk)
    begin
        label_reg  <= label_next;
        coords_reg <= coords_next;
    end

    assign label  = label_reg;
    assign coords = coords_reg;

endmodule

### src/kth_point_select_lex.sv
// ----------------------------------------------------------------------------
// kth_point_select_lex
// Rank-k point selector over a stable, cyclic lexicographic order.
// ----------------------------------------------------------------------------
// Usage:
//   Points arrive on the points channel, one item per cycle while ready is
//   high. Each item is placed in sorted position at once by a row of
//   MAX_POINTS cells; ties keep arrival order. The item with last_point set
//   ends the set, and its target_rank picks the answer.
//   After the last item the chain shifts labels toward cell 0, one cell per
//   cycle, target_rank times; the result item is then loaded into the output
//   register. On error nothing shifts and an error result is loaded instead;
//   ready is low only during the drain.
//   The result register waits for the receiver; loading of the next set goes
//   on while it waits, and a later drain ends only once the register is free.
//   Points beyond MAX_POINTS are dropped, the last mark still counts.
//   Reset empties the set, clears the result valid flag and restores
//   axis_count = 1 and start_axis = 0; there is no clearing pass.
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// ----------------------------------------------------------------------------
module kth_point_select_lex
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [kpsl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kpsl_pkg::CFG_DATA_W-1:0] cfg_data,
    kpsl_point_if.sink                      points,
    kpsl_result_if.source                   result
);
    import kpsl_pkg::*;

    // configuration registers
    logic [AXC_W-1:0] axis_count_reg;
    logic [AXS_W-1:0] start_axis_reg;

    // control state
    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [RANK_W-1:0]  rank_reg;
    logic [RANK_W-1:0]  rank_next;
    logic               err_reg;
    logic               err_next;
    logic               out_valid_reg;
    logic [LABEL_W-1:0] out_label_reg;
    logic               out_status_reg;

    logic               in_acc;
    logic               full;
    logic               slot_free;
    logic               load_out;
    logic [CNT_W-1:0]   cnt_after;
    logic [EFF_W-1:0]   eff_cnt;
    cell_ctrl_t         ctrl;
    coords_t            key_coords;

    logic [LABEL_W-1:0] cell_label  [MAX_POINTS];
    coords_t            cell_coords [MAX_POINTS];
    logic               cell_gt     [MAX_POINTS];

    // axis visited at a given offset from the start axis, modulo the count
    function automatic axis_idx_t axis_at(input logic [AXS_W-1:0] start,
                                          input int off,
                                          input logic [EFF_W-1:0] cnt);
        logic [EFF_W+AXS_W:0] sum;
        sum = (EFF_W + AXS_W + 1)'(start) + (EFF_W + AXS_W + 1)'(off);
        for (int s = 0; s < MAX_DIMS + 3; s++)
        begin
            if ((cnt != '0) && (sum >= (EFF_W + AXS_W + 1)'(cnt)))
            begin
                sum = sum - (EFF_W + AXS_W + 1)'(cnt);
            end
        end
        return sum[AX_W-1:0];
    endfunction

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_count_reg <= AXC_W'(1);
            start_axis_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_AXIS_COUNT: axis_count_reg <= cfg_data[AXC_W-1:0];
                CFG_START_AXIS: start_axis_reg <= cfg_data[AXS_W-1:0];
                default:        ;
            endcase
        end
    end

    // effective axis count and visiting order
    assign eff_cnt = (int'(axis_count_reg) < MAX_DIMS) ? EFF_W'(axis_count_reg)
                                                       : EFF_W'(MAX_DIMS);

    always_comb
    begin
        for (int off = 0; off < MAX_DIMS; off++)
        begin
            ctrl.axis_order[off] = axis_at(start_axis_reg, off, eff_cnt);
        end
    end

    // incoming key, axes past the four fields read as zero
    always_comb
    begin
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            unique case (d)
                0:       key_coords[d] = points.coord_0;
                1:       key_coords[d] = points.coord_1;
                2:       key_coords[d] = points.coord_2;
                3:       key_coords[d] = points.coord_3;
                default: key_coords[d] = '0;
            endcase
        end
    end

    assign in_acc    = points.valid && points.ready;
    assign full      = (count_reg == CNT_W'(MAX_POINTS));
    assign cnt_after = full ? count_reg : count_reg + CNT_W'(1);
    assign slot_free = !out_valid_reg || result.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc && points.last_point)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if ((err_reg || (rank_reg == '0)) && slot_free)
                begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // state outputs
    always_comb
    begin
        points.ready = (state_reg == ST_LOAD);
        ctrl.eff_cnt = eff_cnt;
        ctrl.insert  = in_acc && !full;
        ctrl.shift   = (state_reg == ST_DRAIN) && !err_reg && (rank_reg != '0);
        load_out     = (state_reg == ST_DRAIN) && (err_reg || (rank_reg == '0))
                       && slot_free;
    end

    // set bookkeeping
    always_comb
    begin
        count_next = count_reg;
        rank_next  = rank_reg;
        err_next   = err_reg;
        if (in_acc)
        begin
            if (points.last_point)
            begin
                count_next = '0;
                rank_next  = points.target_rank;
                err_next   = !(CNT_W'(points.target_rank) < cnt_after) ||
                             !(EFF_W'(start_axis_reg) < eff_cnt);
            end
            else if (!full)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        else if (ctrl.shift)
        begin
            rank_next = rank_reg - RANK_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            rank_reg  <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rank_reg  <= rank_next;
            err_reg   <= err_next;
        end
    end

    // insertion chain
    for (genvar i = 0; i < MAX_POINTS; i++)
    begin : g_cell
        logic               prev_gt;
        logic [LABEL_W-1:0] prev_label;
        coords_t            prev_coords;
        logic [LABEL_W-1:0] next_label;

        if (i == 0)
        begin : g_head
            assign prev_gt     = 1'b0;
            assign prev_label  = '0;
            assign prev_coords = '0;
        end
        else
        begin : g_body
            assign prev_gt     = cell_gt[i-1];
            assign prev_label  = cell_label[i-1];
            assign prev_coords = cell_coords[i-1];
        end

        if (i == MAX_POINTS - 1)
        begin : g_tail
            assign next_label = '0;
        end
        else
        begin : g_link
            assign next_label = cell_label[i+1];
        end

        kpsl_cell u_cell
        (
            .clk         (clk),
            .ctrl        (ctrl),
            .occupied    (CNT_W'(i) < count_reg),
            .key_label   (points.point_label),
            .key_coords  (key_coords),
            .prev_gt     (prev_gt),
            .prev_label  (prev_label),
            .prev_coords (prev_coords),
            .next_label  (next_label),
            .gt          (cell_gt[i]),
            .label       (cell_label[i]),
            .coords      (cell_coords[i])
        );
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_label_reg  <= err_reg ? '0 : cell_label[0];
            out_status_reg <= err_reg ? STATUS_ERR : STATUS_OK;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.selected_label = out_label_reg;
    assign result.status         = out_status_reg;

endmodule

### src/kpsl_checker.sv
// ----------------------------------------------------------------------------
// kpsl_checker
// Port-level checks of the rank-k point selector, bound to the top level.
// ----------------------------------------------------------------------------
module kpsl_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         in_last,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [kpsl_pkg::LABEL_W-1:0] out_label,
    input logic                         out_status
);
    import kpsl_pkg::*;

    // a waiting result holds still
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_label) && $stable(out_status))
        else $error("result changed while stalled");

    // an error result carries label zero
    a_err_label: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status == STATUS_ERR) |-> (out_label == '0))
        else $error("error result with nonzero label");

    // the last item of a set is followed by a drain cycle
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("input ready right after last item");

    // a fresh result appears only out of a drain
    a_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a drain");

endmodule

bind kth_point_select_lex kpsl_checker u_kpsl_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (points.valid),
    .in_ready   (points.ready),
    .in_last    (points.last_point),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_label  (result.selected_label),
    .out_status (result.status)
);

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the rank-k point selector against a scoreboard that keeps its own
// stable sorted copy of each set. Directed sets cover field extremes, ties,
// error cases and configuration changes in the middle of a set. They are
// followed by random sets under random axis settings, with random gaps on
// both channels except in one quiet phase.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kpsl_pkg::*;

    localparam int SETTLE    = 4;
    localparam int RAND_GOAL = 650;
    localparam int REPORT_N  = 10;
    localparam logic [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    typedef struct
    {
        logic [LABEL_W-1:0] label;
        coords_t            coords;
        logic [RANK_W-1:0]  rank;
        logic               last;
    } point_t;

    typedef struct
    {
        logic [LABEL_W-1:0] label;
        logic               status;
    } answer_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    kpsl_point_if  pt_ch ();
    kpsl_result_if res_ch ();

    kth_point_select_lex DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .points    (pt_ch),
        .result    (res_ch)
    );

    // stimulus and scoreboard state
    point_t             points_waiting[$];
    answer_t            answers_due[$];
    point_t             on_bus;
    answer_t            want;
    bit                 bus_busy;
    bit                 quiet;
    int                 fault_count;
    int                 rand_items;

    // scoreboard copy of the configuration and of the sorted set
    logic [AXC_W-1:0]   axis_cfg;
    logic [AXS_W-1:0]   start_cfg;
    int                 held;
    logic [LABEL_W-1:0] rank_label[MAX_POINTS];
    coords_t            rank_key[MAX_POINTS];

    always #5 clk = ~clk;

    function automatic int axes_in_use();
        return (axis_cfg < MAX_DIMS) ? int'(axis_cfg) : MAX_DIMS;
    endfunction

    // -1, 0 or 1: cyclic lexicographic order of a against b
    function automatic int order_of(coords_t a, coords_t b);
        int eff;
        int ax;
        eff = axes_in_use();
        for (int off = 0; off < eff; off++)
        begin
            ax = (int'(start_cfg) + off) % eff;
            if ($signed(a[ax]) < $signed(b[ax]))
                return -1;
            if ($signed(a[ax]) > $signed(b[ax]))
                return 1;
        end
        return 0;
    endfunction

    // stable insertion of one point, answer on the last mark
    function automatic void place_point(point_t p);
        int slot;
        answer_t ans;
        if (held < MAX_POINTS)
        begin
            slot = 0;
            while (slot < held && order_of(rank_key[slot], p.coords) <= 0)
                slot++;
            for (int i = held; i > slot; i--)
            begin
                rank_label[i] = rank_label[i-1];
                rank_key[i]   = rank_key[i-1];
            end
            rank_label[slot] = p.label;
            rank_key[slot]   = p.coords;
            held++;
        end
        if (p.last)
        begin
            if (p.rank < held && start_cfg < axes_in_use())
            begin
                ans.label  = rank_label[p.rank];
                ans.status = STATUS_OK;
            end
            else
            begin
                ans.label  = '0;
                ans.status = STATUS_ERR;
            end
            answers_due.push_back(ans);
            held = 0;
        end
    endfunction

    // point channel driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_ch.valid <= 1'b0;
            bus_busy = 1'b0;
        end
        else
        begin
            if (pt_ch.valid && pt_ch.ready)
                place_point(on_bus);
            if (!pt_ch.valid || pt_ch.ready)
            begin
                if (points_waiting.size() != 0 && (quiet || $urandom_range(0, 99) >= 13))
                begin
                    on_bus = points_waiting.pop_front();
                    bus_busy = 1'b1;
                    pt_ch.valid       <= 1'b1;
                    pt_ch.point_label <= on_bus.label;
                    pt_ch.coord_0     <= on_bus.coords[0];
                    pt_ch.coord_1     <= on_bus.coords[1];
                    pt_ch.coord_2     <= on_bus.coords[2];
                    pt_ch.coord_3     <= on_bus.coords[3];
                    pt_ch.target_rank <= on_bus.rank;
                    pt_ch.last_point  <= on_bus.last;
                end
                else
                begin
                    bus_busy = 1'b0;
                    pt_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result channel monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (answers_due.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_N)
                        $display("unexpected result item: label %0d status %0d",
                                 res_ch.selected_label, res_ch.status);
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (res_ch.selected_label !== want.label || res_ch.status !== want.status)
                    begin
                        fault_count++;
                        if (fault_count <= REPORT_N)
                            $display({"result mismatch: expected label %0d status %0d, ",
                                      "got label %0d status %0d"},
                                     want.label, want.status,
                                     res_ch.selected_label, res_ch.status);
                    end
                end
            end
            res_ch.ready <= quiet || ($urandom_range(0, 99) >= 13);
        end
    end

    // hold off until every item is in and every answer is out
    task automatic wait_idle();
        while (points_waiting.size() != 0 || bus_busy || answers_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_AXIS_COUNT)
            axis_cfg = data;
        else if (idx == CFG_START_AXIS)
            start_cfg = data[AXS_W-1:0];
    endtask

    // random axis settings, mostly legal
    task automatic pick_config();
        int axc;
        int eff;
        int sa;
        axc = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
        eff = (axc < MAX_DIMS) ? axc : MAX_DIMS;
        if (eff == 0 || $urandom_range(0, 5) == 0)
            sa = $urandom_range(0, 3);
        else
            sa = $urandom_range(0, eff - 1);
        write_reg(CFG_AXIS_COUNT, CFG_DATA_W'(axc));
        write_reg(CFG_START_AXIS, CFG_DATA_W'(sa));
    endtask

    task automatic add_point(input logic [LABEL_W-1:0] label,
                             input logic [COORD_WIDTH-1:0] c0, c1, c2, c3,
                             input int rank, input bit last);
        point_t p;
        p.label     = label;
        p.coords[0] = c0;
        p.coords[1] = c1;
        p.coords[2] = c2;
        p.coords[3] = c3;
        p.rank      = RANK_W'(rank);
        p.last      = last;
        points_waiting.push_back(p);
    endtask

    // mix of tie-prone small values, extremes and full-range values
    function automatic logic [COORD_WIDTH-1:0] pick_coord();
        int unsigned sel;
        logic [COORD_WIDTH-1:0] v;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            v = $urandom_range(0, 4) - 2;
        else if (sel == 5)
        begin
            case ($urandom_range(0, 3))
                0: v = CMAX;
                1: v = CMIN;
                2: v = '0;
                default: v = '1;
            endcase
        end
        else
            v = $urandom();
        return v;
    endfunction

    // one random set, sometimes with a configuration change part way in
    task automatic queue_set(input int size);
        point_t p;
        int cut;
        int span;
        cut  = ($urandom_range(0, 14) == 0) ? $urandom_range(1, size) : 0;
        span = (size < MAX_POINTS) ? size : MAX_POINTS;
        for (int i = 0; i < size; i++)
        begin
            if (cut != 0 && i == cut)
            begin
                wait_idle();
                pick_config();
            end
            p.label = LABEL_W'($urandom_range(0, 65535));
            for (int d = 0; d < MAX_DIMS; d++)
                p.coords[d] = pick_coord();
            p.last = (i == size - 1);
            if (p.last && $urandom_range(0, 4) != 0)
                p.rank = RANK_W'($urandom_range(0, span - 1));
            else
                p.rank = RANK_W'($urandom_range(0, 63));
            points_waiting.push_back(p);
        end
        rand_items += size;
    endtask

    // main sequence
    initial
    begin
        int phase;
        int phase_end;
        int size;

        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        pt_ch.valid = 1'b0;
        pt_ch.point_label = '0;
        pt_ch.coord_0     = '0;
        pt_ch.coord_1     = '0;
        pt_ch.coord_2     = '0;
        pt_ch.coord_3     = '0;
        pt_ch.target_rank = '0;
        pt_ch.last_point  = 1'b0;
        res_ch.ready      = 1'b0;
        quiet       = 1'b0;
        fault_count = 0;
        rand_items  = 0;
        held        = 0;
        axis_cfg    = 1;
        start_cfg   = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: one axis from axis 0, field extremes
        add_point(16'h0000, CMAX, CMIN, CMAX, CMIN, 63, 1'b0);
        add_point(16'hFFFF, CMIN, CMAX, CMIN, CMAX, 0, 1'b0);
        add_point(16'h1234, '0, '1, '0, '1, 0, 1'b0);
        add_point(16'hABCD, '1, '0, '1, '0, 1, 1'b1);
        add_point(16'h5A5A, 7, 7, 7, 7, 0, 1'b1);
        // rank past the set size
        add_point(16'h0001, 3, 0, 0, 0, 63, 1'b1);
        wait_idle();

        // four axes from axis 3, wrap to axis 0 on a tie
        write_reg(CFG_AXIS_COUNT, 4);
        write_reg(CFG_START_AXIS, 3);
        add_point(16'h0101, 9, 0, 0, 5, 0, 1'b0);
        add_point(16'h0202, -9, 0, 0, 5, 0, 1'b0);
        add_point(16'h0303, 0, 0, 0, CMIN, 2, 1'b1);
        wait_idle();

        // zero axes in use: always an error
        write_reg(CFG_AXIS_COUNT, 0);
        add_point(16'h0404, 1, 2, 3, 4, 0, 1'b0);
        add_point(16'h0505, -1, -2, -3, -4, 0, 1'b1);
        wait_idle();

        // axis count above the limit, identical points keep arrival order
        write_reg(CFG_AXIS_COUNT, 7);
        add_point(16'h0AAA, 2, 2, 2, 2, 0, 1'b0);
        add_point(16'h0BBB, 2, 2, 2, 2, 0, 1'b0);
        add_point(16'h0CCC, 2, 2, 2, 2, 1, 1'b1);
        wait_idle();

        // start axis beyond the axis count
        write_reg(CFG_AXIS_COUNT, 2);
        add_point(16'h0606, 5, 1, 0, 0, 0, 1'b0);
        add_point(16'h0707, 4, 2, 0, 0, 0, 1'b1);
        wait_idle();

        // order changes part way through a set
        write_reg(CFG_START_AXIS, 0);
        add_point(16'h0808, 1, 9, 0, 0, 0, 1'b0);
        add_point(16'h0909, 2, 8, 0, 0, 0, 1'b0);
        wait_idle();
        write_reg(CFG_START_AXIS, 1);
        add_point(16'h0A0A, 3, 7, 0, 0, 0, 1'b0);
        add_point(16'h0B0B, 0, 8, 0, 0, 3, 1'b1);
        wait_idle();

        // random phases, each under its own settings
        phase = 0;
        while (rand_items < RAND_GOAL)
        begin
            wait_idle();
            pick_config();
            quiet = (phase == 2);
            phase_end = rand_items + 80;
            if (phase == 1)
                queue_set(MAX_POINTS + 1);
            while (rand_items < phase_end && rand_items < RAND_GOAL)
            begin
                size = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70)
                                                    : $urandom_range(1, 12);
                queue_set(size);
            end
            phase++;
        end

        wait_idle();
        quiet = 1'b0;
        repeat (MAX_POINTS + 8) @(posedge clk);
        if (fault_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #3000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
